@@ design/assert_macros.svh @@
// assertion helpers used by the resampler top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// consequent required in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/lir_pkg.sv @@
package lir_pkg;

	localparam int SampleW      = 16;
	localparam int StepW        = 21;
	localparam int PhaseW       = 22;
	localparam int FracW        = 16;
	localparam int RingIdxW     = 10;
	localparam int MaxOut       = 16;
	localparam int CntW         = 4;
	localparam int RingDepthDef = 1024;

	localparam logic [PhaseW-1:0] OneFix    = PhaseW'(65536);
	localparam logic [StepW-1:0]  StepReset = StepW'(65536);

	typedef struct packed {
		logic signed [SampleW-1:0] sample_in;
		logic                      block_end;
	} src_t;

	typedef struct packed {
		logic signed [SampleW-1:0] sample_out;
		logic [RingIdxW-1:0]       ring_index;
		logic                      run_last;
		logic                      block_end_out;
	} res_t;

endpackage

@@ design/lir_interp_unit.sv @@
module lir_interp_unit (
	input  logic                                clk,
	input  logic                                load,
	input  logic signed [lir_pkg::SampleW-1:0]  a,
	input  logic signed [lir_pkg::SampleW-1:0]  b,
	input  logic [lir_pkg::FracW-1:0]           frac,
	output logic signed [lir_pkg::SampleW-1:0]  result
);
	import lir_pkg::*;

	localparam int DiffW = SampleW + 1;
	localparam int ProdW = DiffW + FracW;
	localparam int WideW = ProdW + 1;

	logic signed [DiffW-1:0]   diff;
	logic signed [DiffW-1:0]   frac_s;
	logic signed [ProdW-1:0]   prod_s1;
	logic signed [SampleW-1:0] a_s1;
	logic signed [WideW-1:0]   wide;
	logic                      round_up;

	assign diff   = $signed({b[SampleW-1], b}) - $signed({a[SampleW-1], a});
	assign frac_s = $signed({1'b0, frac});

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= ProdW'(diff) * ProdW'(frac_s);
			a_s1    <= a;
		end
	end

	// a * 2^16 plus the weighted difference, then truncate toward zero
	assign wide = $signed({{(WideW-SampleW-FracW){a_s1[SampleW-1]}}, a_s1, {FracW{1'b0}}})
		+ $signed({prod_s1[ProdW-1], prod_s1});
	assign round_up = wide[WideW-1] && (wide[FracW-1:0] != '0);
	assign result   = $signed(wide[FracW+SampleW-1:FracW] + SampleW'(round_up));

endmodule

@@ design/linear_interp_resampler_top.sv @@
// linear interpolation resampler, one audio channel
// src channel: src_valid / src_stall carry one sample and its block_end mark
// res channel: res_valid / res_stall carry interpolated samples with ring
//   position, run_last and block_end_out flags
// cfg channel: cfg_valid / cfg_ready write resample_step (5.16); cfg_ready
//   is always high, write only while idle
// an accepted sample that makes no output (first sample, or phase already at
// or past 1.0) leaves the block idle and ready for the next sample
// each output passes through a multiply step in the shared interpolation
// unit, a sum and truncate step, then the output register; a sample
// making n outputs keeps src_stall high until its last result has been
// taken, including any time that res_stall holds a result
// up to 16 outputs per input; src_stall stays high while a run is in progress
// a stalled result holds in the output register and the run pauses
// reset clears the previous sample, the phase, the ring pointer and the
// result valid, and sets resample_step to 1.0
`include "assert_macros.svh"

module linear_interp_resampler_top #(
	parameter int RING_DEPTH = lir_pkg::RingDepthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_stall,
	input  lir_pkg::src_t               src_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output lir_pkg::res_t               res_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lir_pkg::StepW-1:0]   cfg_data
);
	import lir_pkg::*;

	localparam int PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StCalc = 2'd1;
	localparam logic [1:0] StSum  = 2'd2;
	localparam logic [1:0] StOut  = 2'd3;

	logic [1:0]                state_q;
	logic [StepW-1:0]          step_q;
	logic signed [SampleW-1:0] prev_q;
	logic signed [SampleW-1:0] cur_q;
	logic                      bend_q;
	logic [PhaseW-1:0]         phase_q;
	logic [PtrW-1:0]           wp_q;
	logic                      have_prev_q;
	logic [CntW-1:0]           cnt_q;
	logic                      res_valid_q;
	res_t                      res_q;

	logic signed [SampleW-1:0] interp_y;
	logic [PhaseW-1:0]         sum_phase;
	logic                      sum_ge_one;
	logic                      at_cap;
	logic                      last_run;
	logic [RingIdxW-1:0]       wp_ext;
	logic                      src_xfer;
	logic                      res_xfer;

	lir_interp_unit u_interp (
		.clk    (clk),
		.load   (state_q == StCalc),
		.a      (prev_q),
		.b      (cur_q),
		.frac   (phase_q[FracW-1:0]),
		.result (interp_y)
	);

	assign src_stall = (state_q != StIdle);
	assign src_xfer  = src_valid && !src_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign res_xfer  = res_valid_q && !res_stall;
	assign cfg_ready = 1'b1;

	assign sum_phase  = phase_q + PhaseW'(step_q);
	assign sum_ge_one = (sum_phase >= OneFix);
	assign at_cap     = (cnt_q == CntW'(MaxOut - 1));
	assign last_run   = sum_ge_one || at_cap;
	assign wp_ext     = RingIdxW'(wp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			step_q      <= StepReset;
			prev_q      <= '0;
			phase_q     <= '0;
			wp_q        <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			case (state_q)
				StIdle: begin
					if (src_xfer) begin
						if (!have_prev_q) begin
							prev_q      <= src_data.sample_in;
							have_prev_q <= 1'b1;
						end else if (phase_q >= OneFix) begin
							// interval already passed, no output for this sample
							phase_q <= phase_q - OneFix;
							prev_q  <= src_data.sample_in;
						end else begin
							cnt_q   <= '0;
							state_q <= StCalc;
						end
					end
				end
				StCalc: begin
					state_q <= StSum;
				end
				StSum: begin
					res_valid_q <= 1'b1;
					wp_q        <= (wp_q == PtrLast) ? '0 : wp_q + PtrW'(1);
					cnt_q       <= cnt_q + CntW'(1);
					if (sum_ge_one) begin
						phase_q <= sum_phase - OneFix;
					end else if (at_cap) begin
						phase_q <= '0;
					end else begin
						phase_q <= sum_phase;
					end
					if (last_run) begin
						prev_q <= cur_q;
					end
					state_q <= StOut;
				end
				StOut: begin
					if (!res_stall) begin
						res_valid_q <= 1'b0;
						state_q     <= res_q.run_last ? StIdle : StCalc;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			cur_q  <= src_data.sample_in;
			bend_q <= src_data.block_end;
		end
		if (state_q == StSum) begin
			res_q.sample_out    <= interp_y;
			res_q.ring_index    <= wp_ext;
			res_q.run_last      <= last_run;
			res_q.block_end_out <= last_run && bend_q;
		end
	end

	// a sample is only taken with the output register empty
	`ASSERT_ALWAYS(a_idle_empty, clk, arst_n, !src_stall |-> !res_valid)
	// the last transfer of a run frees the input side
	`ASSERT_NEXT(a_last_frees, clk, arst_n, res_xfer && res_data.run_last, !src_stall)
	// any other transfer keeps the run going
	`ASSERT_NEXT(a_run_busy, clk, arst_n, res_xfer && !res_data.run_last, src_stall)

endmodule
